### hw/rtl/ipidr_pkg.sv
package ipidr_pkg;

  localparam int unsigned GAIN_W   = 31;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned TS_W     = 16;
  localparam int unsigned DRIVE_W  = 26;
  localparam int unsigned HOLD_W   = 3;
  localparam int unsigned COEF_W   = 49;
  localparam int unsigned SUM_W    = 82;
  localparam int unsigned MUL_A_W  = 33;
  localparam int unsigned MUL_B_W  = 32;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ADDR_W   = 5;

  localparam int unsigned HOLD_STEPS_DEF = 7;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(58982400);
  localparam logic [DRIVE_W-1:0] HALF_Q16  = DRIVE_W'(32768);
  localparam logic [SUM_W-1:0]   SUM_LIMIT = {40'd0, DRIVE_MAX, 16'd0};

  typedef enum logic [2:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_MODE      = 3'd3,
    REG_TARGET_LR = 3'd4,
    REG_TARGET_DR = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_CLAMP,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    MS_KI_TS,
    MS_A_E0,
    MS_C_E2,
    MS_BLO_E1,
    MS_BHI_E1,
    MS_FOLD
  } mstep_e;

endpackage

### hw/rtl/incremental_pid_rate_controller.sv
// Start items: the result is loaded into the output register once that register is free,
// and the next item can be accepted after that load.
// Update items: the result passes through the 31-step radix-2 divider, a check that it
// has finished, six shared-multiplier steps, the clamp and the output load; the next
// item is accepted only after the output load.
// Async reset (rst_ni low) clears registers, error history, output valid and hold count.
module incremental_pid_rate_controller #(
  parameter int unsigned HOLD_STEPS = ipidr_pkg::HOLD_STEPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // tdata: load_rate[31:0], displacement_rate[63:32], interval_ms[79:64].
  input  logic [79:0]                  s_axis_tdata,
  // tuser: op.
  input  logic                         s_axis_tuser,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: drive[25:0], zero above.
  output logic [31:0]                  m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ipidr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ipidr_pkg::*;

  logic [GAIN_W-1:0]        gain_p_q, gain_i_q, gain_d_q;
  logic                     mode_q;
  logic signed [DATA_W-1:0] tgt_lr_q, tgt_dr_q;
  reg_idx_e                 reg_idx;
  logic                     cfg_wr;

  state_e                   state_q, state_d;
  mstep_e                   step_q, step_d;
  logic signed [DATA_W-1:0] e0_q, e0_d, hist0_q, hist0_d, hist1_q, hist1_d;
  logic [DRIVE_W-1:0]       acc_q, acc_d;
  logic [HOLD_W-1:0]        hold_q, hold_d;
  logic [TS_W-1:0]          ts_q, ts_d;
  logic signed [COEF_W-1:0] b_q, b_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic                     mvalid_q, mvalid_d;
  logic [DRIVE_W-1:0]       drive_q, drive_d;

  logic                     accept;
  logic [TS_W-1:0]          ts_in;
  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W-1:0] err_in;
  logic                     div_start, div_done;
  logic [GAIN_W-1:0]        quot;
  logic [TS_W-1:0]          rem;
  logic [DATA_W-1:0]        coef_a, coef_c2;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;
  logic signed [SUM_W-1:0]  addend;

  assign reg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      REG_GAIN_P:    prdata = {1'b0, gain_p_q};
      REG_GAIN_I:    prdata = {1'b0, gain_i_q};
      REG_GAIN_D:    prdata = {1'b0, gain_d_q};
      REG_MODE:      prdata = {31'd0, mode_q};
      REG_TARGET_LR: prdata = tgt_lr_q;
      REG_TARGET_DR: prdata = tgt_dr_q;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= '0;
      gain_i_q <= '0;
      gain_d_q <= '0;
      mode_q   <= 1'b0;
      tgt_lr_q <= '0;
      tgt_dr_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GAIN_P:    gain_p_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:    gain_i_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:    gain_d_q <= pwdata[GAIN_W-1:0];
        REG_MODE:      mode_q   <= pwdata[0];
        REG_TARGET_LR: tgt_lr_q <= pwdata;
        REG_TARGET_DR: tgt_dr_q <= pwdata;
        default:       ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ts_in         = (s_axis_tdata[79:64] == '0) ? TS_W'(1) : s_axis_tdata[79:64];
  assign diff          = mode_q
                         ? ({tgt_dr_q[DATA_W-1], tgt_dr_q}
                            - {s_axis_tdata[63], s_axis_tdata[63:32]})
                         : ({tgt_lr_q[DATA_W-1], tgt_lr_q}
                            - {s_axis_tdata[31], s_axis_tdata[31:0]});
  assign err_in        = (diff[DATA_W] == diff[DATA_W-1]) ? diff[DATA_W-1:0]
                         : {diff[DATA_W], {(DATA_W-1){~diff[DATA_W]}}};
  assign div_start     = accept && !s_axis_tuser;

  ipidr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (gain_d_q),
    .divisor_i  (ts_in),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // The doubled-gain quotient follows from one division: 2q plus one when 2r >= Ts.
  assign coef_a  = {1'b0, gain_p_q} + {1'b0, quot};
  assign coef_c2 = {quot, 1'b0} + DATA_W'({rem, 1'b0} >= {1'b0, ts_q});

  always_comb begin
    case (step_q)
      MS_KI_TS: begin
        mul_a = {2'b00, gain_i_q};
        mul_b = {16'd0, ts_q};
      end
      MS_A_E0: begin
        mul_a = {1'b0, coef_a};
        mul_b = e0_q;
      end
      MS_C_E2: begin
        mul_a = {2'b00, quot};
        mul_b = hist1_q;
      end
      MS_BLO_E1: begin
        mul_a = {1'b0, b_q[31:0]};
        mul_b = hist0_q;
      end
      MS_BHI_E1: begin
        mul_a = {{(MUL_A_W-(COEF_W-32)){b_q[COEF_W-1]}}, b_q[COEF_W-1:32]};
        mul_b = hist0_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ipidr_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    if (step_q == MS_FOLD) begin
      addend = {{(SUM_W-COEF_W-32){prod[COEF_W-1]}}, prod[COEF_W-1:0], 32'd0};
    end else begin
      addend = {{(SUM_W-MUL_P_W){prod[MUL_P_W-1]}}, prod};
    end
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    e0_d     = e0_q;
    hist0_d  = hist0_q;
    hist1_d  = hist1_q;
    acc_d    = acc_q;
    hold_d   = hold_q;
    ts_d     = ts_q;
    b_d      = b_q;
    sum_d    = sum_q;
    mvalid_d = mvalid_q && !m_axis_tready;
    drive_d  = drive_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser) begin
            hist0_d = '0;
            hist1_d = '0;
            hold_d  = HOLD_W'(HOLD_STEPS - 1);
            acc_d   = HALF_Q16;
            state_d = ST_OUT;
          end else begin
            e0_d    = err_in;
            ts_d    = ts_in;
            sum_d   = {{(SUM_W-DRIVE_W-16){1'b0}}, acc_q, 16'd0};
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          step_d  = MS_KI_TS;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        case (step_q)
          MS_KI_TS: step_d = MS_A_E0;
          MS_A_E0: begin
            b_d = $signed({2'b00, prod[COEF_W-3:0]})
                  - $signed({{(COEF_W-GAIN_W){1'b0}}, gain_p_q})
                  - $signed({{(COEF_W-DATA_W){1'b0}}, coef_c2});
            step_d = MS_C_E2;
          end
          MS_C_E2: begin
            sum_d  = sum_q + addend;
            step_d = MS_BLO_E1;
          end
          MS_BLO_E1: begin
            sum_d  = sum_q + addend;
            step_d = MS_BHI_E1;
          end
          MS_BHI_E1: begin
            sum_d  = sum_q + addend;
            step_d = MS_FOLD;
          end
          MS_FOLD: begin
            sum_d   = sum_q + addend;
            state_d = ST_CLAMP;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_CLAMP: begin
        hist1_d = hist0_q;
        hist0_d = e0_q;
        if (sum_q[SUM_W-1]) begin
          acc_d = '0;
        end else if (sum_q >= SUM_LIMIT) begin
          acc_d = DRIVE_MAX;
        end else begin
          acc_d = sum_q[DRIVE_W+15:16];
        end
        if (hold_q != '0) begin
          hold_d = hold_q - 1'b1;
          acc_d  = HALF_Q16;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          drive_d  = acc_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= MS_KI_TS;
      hist0_q  <= '0;
      hist1_q  <= '0;
      acc_q    <= '0;
      hold_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      hist0_q  <= hist0_d;
      hist1_q  <= hist1_d;
      acc_q    <= acc_d;
      hold_q   <= hold_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q    <= e0_d;
    ts_q    <= ts_d;
    b_q     <= b_d;
    sum_q   <= sum_d;
    drive_q <= drive_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {{(32-DRIVE_W){1'b0}}, drive_q};

endmodule

### hw/rtl/ipidr_div.sv
module ipidr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ipidr_pkg::GAIN_W-1:0]  dividend_i,
  input  logic [ipidr_pkg::TS_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [ipidr_pkg::GAIN_W-1:0]  quot_o,
  output logic [ipidr_pkg::TS_W-1:0]    rem_o
);
  import ipidr_pkg::*;

  localparam int unsigned CNT_W = $clog2(GAIN_W);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [GAIN_W-1:0]   quot_q, quot_d;
  logic [TS_W-1:0]     rem_q, rem_d;
  logic [TS_W-1:0]     dsr_q, dsr_d;
  logic [TS_W:0]       shifted;
  logic                ge;

  always_comb begin
    shifted = {rem_q, quot_q[GAIN_W-1]};
    ge      = shifted >= {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[GAIN_W-2:0], ge};
      rem_d  = ge ? TS_W'(shifted - {1'b0, dsr_q}) : shifted[TS_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(GAIN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

### hw/rtl/ipidr_mul.sv
module ipidr_mul (
  input  logic                                clk_i,
  input  logic signed [ipidr_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [ipidr_pkg::MUL_B_W-1:0] b_i,
  output logic signed [ipidr_pkg::MUL_P_W-1:0] prod_o
);
  import ipidr_pkg::*;

  logic signed [MUL_P_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipidr_pkg::*;

  localparam int unsigned HOLD_LEN  = HOLD_STEPS_DEF;
  localparam longint      DRIVE_LIM = longint'({DRIVE_MAX, 16'h0000});

  logic                clk_i;
  logic                rst_ni;
  logic [79:0]         s_axis_tdata;
  logic                s_axis_tuser;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  incremental_pid_rate_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow copy of the controller registers and loop state.
  logic [30:0]  kp, ki, kd;
  logic         mode_disp;
  int           tgt_load, tgt_disp;
  int           err_prev, err_prev2;
  logic [31:0]  acc_drive;
  int unsigned  hold_left;

  logic [31:0]  drive_q[$];
  int           fails;
  int           idle_en;
  int           sink_stall;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [31:0] predict_drive(bit op, int lr, int dr, int unsigned ts_in);
    longint unsigned   tsq;
    longint            diff, cq, aq, bq;
    int                e0;
    logic signed [99:0] wa, wb, wc, w0, w1, w2, wacc, total;
    if (op) begin
      err_prev  = 0;
      err_prev2 = 0;
      hold_left = HOLD_LEN;
    end else begin
      tsq = (ts_in == 0) ? 64'd1 : longint'(ts_in);
      if (mode_disp) begin
        diff = longint'(tgt_disp) - longint'(dr);
      end else begin
        diff = longint'(tgt_load) - longint'(lr);
      end
      if (diff > 64'sd2147483647) diff = 64'sd2147483647;
      if (diff < -64'sd2147483648) diff = -64'sd2147483648;
      e0 = int'(diff);
      cq = longint'(longint'(kd) / tsq);
      aq = longint'(kp) + cq;
      bq = longint'(longint'(ki) * tsq) - longint'(kp) - longint'((longint'(kd) * 2) / tsq);
      wa = aq;
      wb = bq;
      wc = cq;
      w0 = e0;
      w1 = err_prev;
      w2 = err_prev2;
      wacc = '0;
      wacc[47:0] = {acc_drive, 16'h0000};
      total = wa * w0 + wb * w1 + wc * w2 + wacc;
      err_prev2 = err_prev;
      err_prev  = e0;
      if (total < 0) begin
        acc_drive = '0;
      end else if (total >= DRIVE_LIM) begin
        acc_drive = 32'(DRIVE_MAX);
      end else begin
        acc_drive = total[47:16];
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      acc_drive = 32'(HALF_Q16);
    end
    return {6'd0, acc_drive[25:0]};
  endfunction

  task automatic check_drive(logic [31:0] got);
    logic [31:0] want;
    if (drive_q.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected drive item %h", got);
    end else begin
      want = drive_q.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10) $display("drive mismatch: expected %h, got %h", want, got);
      end
    end
  endtask

  task automatic send_item(bit op, int lr, int dr, int unsigned ts);
    int gap;
    gap = idle_en ? $urandom_range(0, 17) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tdata  = {ts[15:0], dr, lr};
    s_axis_tuser  = op;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    drive_q.push_back(predict_drive(op, lr, dr, ts[15:0]));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [31:0] val);
    wait_idle();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_GAIN_P:    kp = val[30:0];
      REG_GAIN_I:    ki = val[30:0];
      REG_GAIN_D:    kd = val[30:0];
      REG_MODE:      mode_disp = val[0];
      REG_TARGET_LR: tgt_load = val;
      REG_TARGET_DR: tgt_disp = val;
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_loop(logic [31:0] p, logic [31:0] i, logic [31:0] d, bit m,
                          logic [31:0] tl, logic [31:0] td);
    cfg_write(REG_GAIN_P, p);
    cfg_write(REG_GAIN_I, i);
    cfg_write(REG_GAIN_D, d);
    cfg_write(REG_MODE, {31'd0, m});
    cfg_write(REG_TARGET_LR, tl);
    cfg_write(REG_TARGET_DR, td);
  endtask

  function automatic int near_target();
    int span;
    span = 1 << $urandom_range(2, 26);
    return (mode_disp ? tgt_disp : tgt_load) - (int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic int unsigned pick_interval();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    if (r == 2) return $urandom_range(0, 65535);
    return $urandom_range(1, 40);
  endfunction

  task automatic send_update_near();
    int meas;
    int other;
    meas  = near_target();
    other = $urandom;
    if (mode_disp) begin
      send_item(1'b0, other, meas, pick_interval());
    end else begin
      send_item(1'b0, meas, other, pick_interval());
    end
  endtask

  task automatic test_reset_defaults();
    idle_en = 1;
    repeat (3) send_item(1'b0, $urandom, $urandom, $urandom_range(0, 65535));
  endtask

  task automatic test_directed();
    idle_en = 1;
    set_loop(32'd65536, 32'd6554, 32'd32768, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    // Saturated error and zero interval before any start item.
    send_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_item(1'b0, 32'h0000_0000, 32'h0000_0000, 65535);
    send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 65535);
    repeat (HOLD_LEN - 1) send_item(1'b0, 32'h8000_0000, 32'h0000_0000, 1);
    send_item(1'b0, 32'h8000_0000, 32'h0000_0000, 1);
    send_item(1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 0);
    cfg_write(REG_MODE, 32'd1);
    repeat (3) send_item(1'b0, 32'h0000_0000, 32'h7FFF_FFFF, 65535);
    send_item(1'b1, 32'h0000_0000, 32'h0000_0000, 0);
    for (int k = 0; k < HOLD_LEN; k++) begin
      send_item(1'b0, 32'h5555_5555, 32'h8000_0000, k);
    end
  endtask

  task automatic test_backpressure();
    set_loop(32'd65536, 32'd3277, 32'd16384, 1'b0, 32'h0010_0000, 32'hFFF0_0000);
    idle_en = 0;
    sink_stall = 400;
    send_item(1'b1, $urandom, $urandom, 0);
    repeat (30) send_update_near();
  endtask

  task automatic run_random_phase(int n);
    int sent;
    int runlen;
    sent = 0;
    while (sent < n) begin
      idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_item($urandom_range(0, 1), $urandom, $urandom, $urandom_range(0, 65535));
          sent++;
        end
      end else begin
        runlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : $urandom_range(7, 30);
        send_item(1'b1, $urandom, $urandom, $urandom_range(0, 65535));
        sent++;
        repeat (runlen) begin
          send_update_near();
          sent++;
        end
      end
    end
  endtask

  function automatic logic [31:0] mid_target();
    return int'($urandom_range(0, 1 << 25)) - (1 << 24);
  endfunction

  task automatic test_random_settings();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_loop(32'd65536, 32'd655, 32'd32768, 1'b0, mid_target(), mid_target());
        1: set_loop(32'd16384, 32'd6554, 32'd131072, 1'b1, mid_target(), mid_target());
        2: set_loop(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0,
                    32'h7FFF_FFFF, 32'h8000_0000);
        3: set_loop(32'd0, 32'd0, 32'd0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        4: set_loop($urandom_range(0, 1 << 19), $urandom_range(0, 1 << 16),
                    $urandom_range(0, 1 << 19), $urandom_range(0, 1),
                    mid_target(), mid_target());
        default: set_loop($urandom, $urandom, $urandom, $urandom_range(0, 1),
                          $urandom, $urandom);
      endcase
      run_random_phase(140);
    end
  endtask

  initial begin
    int stall;
    int gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (sink_stall > 0) begin
        stall = sink_stall;
        sink_stall = 0;
        repeat (stall) begin
          @(negedge clk_i);
          m_axis_tready = 1'b0;
        end
      end
      gap = idle_en ? $urandom_range(0, 17) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_drive(m_axis_tdata);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tvalid = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    kp            = '0;
    ki            = '0;
    kd            = '0;
    mode_disp     = 1'b0;
    tgt_load      = 0;
    tgt_disp      = 0;
    err_prev      = 0;
    err_prev2     = 0;
    acc_drive     = '0;
    hold_left     = 0;
    fails         = 0;
    idle_en       = 1;
    sink_stall    = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random_settings();

    wait_idle();
    repeat (50) @(posedge clk_i);
    fails += drive_q.size();
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ipidr_pkg.sv
hw/rtl/ipidr_div.sv
hw/rtl/ipidr_mul.sv
hw/rtl/incremental_pid_rate_controller.sv
sim/tb.sv
